@@ src/sft_pkg.sv @@
// ----------------------------------------------------------------------------
// sft_pkg
// Types, codes and the liveness rule shared by the signal freshness tracker.
// ----------------------------------------------------------------------------
package sft_pkg;

	localparam int ADDR_W = 4;

	localparam logic [15:0] FLOOR_RESET   = 16'd250;
	localparam logic [15:0] CEILING_RESET = 16'd60000;
	localparam logic [15:0] DEFAULT_RESET = 16'd1000;

	localparam logic [1:0] REG_FLOOR   = 2'd0;
	localparam logic [1:0] REG_CEILING = 2'd1;
	localparam logic [1:0] REG_DEFAULT = 2'd2;

	localparam logic [1:0] KIND_READING = 2'd0;
	localparam logic [1:0] KIND_QUERY   = 2'd1;
	localparam logic [1:0] KIND_SCAN    = 2'd2;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_NODE_FULL  = 2'd1;
	localparam logic [1:0] STATUS_SLOTS_FULL = 2'd2;
	localparam logic [1:0] STATUS_NOT_FOUND  = 2'd3;

	localparam logic [1:0] LIVE_OK    = 2'd0;
	localparam logic [1:0] LIVE_LATE  = 2'd1;
	localparam logic [1:0] LIVE_STALE = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         node_id;
		logic [15:0]        subject_key;
		logic               has_value;
		logic signed [31:0] sample_value;
		logic [31:0]        now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [1:0]         liveness;
		logic [31:0]        mean_period;
		logic signed [31:0] history_min;
		logic signed [31:0] history_max;
		logic [6:0]         history_fill;
		logic [7:0]         overdue_total;
		logic [7:0]         stale_total;
	} out_item_t;

	typedef struct packed {
		logic [15:0] floor_ms;
		logic [15:0] ceiling_ms;
		logic [15:0] default_ms;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_READING,
		OP_QUERY,
		OP_SCAN,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t      op;
		in_item_t item;
	} queue_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NODE,
		ST_SLOT_RD,
		ST_SLOT_CMP,
		ST_UPDATE,
		ST_RING_RD,
		ST_RING_EVAL,
		ST_WRITE,
		ST_SCAN_RD,
		ST_SCAN_EVAL,
		ST_DONE
	} state_t;

	// live / late / stale against the clamped period
	function automatic logic [1:0] judge(input logic [31:0] arrivals, input logic [31:0] period,
			input logic [31:0] last, input logic [31:0] now, input cfg_t cfg);
		logic [31:0] pw;
		logic [15:0] p;
		logic [31:0] age;
		logic [18:0] p5;
		logic [18:0] p6;
		logic [1:0]  res;
		pw = (period == 32'd0) ? {16'd0, cfg.default_ms} : period;
		if (pw < {16'd0, cfg.floor_ms}) begin
			p = cfg.floor_ms;
		end else if (pw > {16'd0, cfg.ceiling_ms}) begin
			p = cfg.ceiling_ms;
		end else begin
			p = pw[15:0];
		end
		age = now - last;
		p5  = {1'b0, p, 2'b00} + {3'd0, p};
		p6  = {1'b0, p, 2'b00} + {2'd0, p, 1'b0};
		if (arrivals == 32'd0) begin
			res = LIVE_STALE;
		end else if (age <= {14'd0, p5[18:1]}) begin
			res = LIVE_OK;
		end else if (age <= {13'd0, p6}) begin
			res = LIVE_LATE;
		end else begin
			res = LIVE_STALE;
		end
		return res;
	endfunction

endpackage

@@ src/sft_front.sv @@
// ----------------------------------------------------------------------------
// sft_front
// Accepts items, tags each with its operation and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module sft_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  sft_pkg::in_item_t     in_item,
	output logic                  q_valid,
	output sft_pkg::queue_entry_t q_entry,
	input  logic                  q_pop
);

	sft_pkg::queue_entry_t buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	sft_pkg::op_t op;

	always_comb begin
		unique case (in_item.kind)
			sft_pkg::KIND_READING: op = sft_pkg::OP_READING;
			sft_pkg::KIND_QUERY:   op = sft_pkg::OP_QUERY;
			sft_pkg::KIND_SCAN:    op = sft_pkg::OP_SCAN;
			default:               op = sft_pkg::OP_NONE;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_entry  = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= '{op: op, item: in_item};
		end
	end

endmodule

@@ src/sft_back.sv @@
// ----------------------------------------------------------------------------
// sft_back
// Sequencer that searches the node table, walks the signal slots and the
// history ring, and delivers one result per item through an output register.
// ----------------------------------------------------------------------------
module sft_back #(
	parameter int NODE_SLOTS       = 16,
	parameter int SIGNALS_PER_NODE = 8,
	parameter int RING_DEPTH       = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sft_pkg::cfg_t         cfg,
	input  logic                  q_valid,
	input  sft_pkg::queue_entry_t q_entry,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output sft_pkg::out_item_t    out_item
);

	localparam int SLOTS  = NODE_SLOTS * SIGNALS_PER_NODE;
	localparam int ND_W   = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(SIGNALS_PER_NODE + 1);
	localparam int SL_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HEAD_W = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int RA_W   = $clog2(SLOTS * RING_DEPTH);

	typedef struct packed {
		logic [15:0]        subject;
		logic [31:0]        period;
		logic [31:0]        last;
		logic [31:0]        arrivals;
		logic [HEAD_W-1:0]  head;
		logic [FILL_W-1:0]  fill;
		logic signed [31:0] low;
		logic signed [31:0] high;
	} rec_t;

	sft_pkg::state_t state_q, state_d;

	logic             node_used_q  [NODE_SLOTS];
	logic [7:0]       node_ident_q [NODE_SLOTS];
	logic [CNT_W-1:0] node_cnt_q   [NODE_SLOTS];

	rec_t slot_mem [SLOTS];
	rec_t slot_rd_q;
	logic signed [31:0] ring_mem [SLOTS * RING_DEPTH];
	logic signed [31:0] ring_rd_q;

	sft_pkg::queue_entry_t ent_q;
	logic [ND_W-1:0]   nd_q;
	logic [CNT_W-1:0]  k_q;
	logic [SL_W-1:0]   sl_q;
	logic [FILL_W-1:0] j_q;
	rec_t              rec_q;
	logic signed [31:0] lo_q, hi_q;
	logic [7:0]        overdue_q, stale_q;
	sft_pkg::out_item_t res_q;
	logic              out_valid_q;
	sft_pkg::out_item_t out_item_q;

	logic            hit, free;
	logic [ND_W-1:0] hit_idx, free_idx;
	logic [SL_W-1:0] base_addr, alloc_addr;
	logic            slot_more, cnt_full, subj_match, ring_last, last_node;
	logic            slot_we, ring_we;
	logic [SL_W-1:0] slot_ra;
	logic [RA_W-1:0] ring_wa, ring_ra;
	logic [1:0]      scan_live;
	logic [31:0]     gap, sum3;
	logic signed [31:0] lo_n, hi_n;
	logic            out_load;

	// node search, lowest index first
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free     = 1'b0;
		free_idx = '0;
		for (int i = NODE_SLOTS - 1; i >= 0; i--) begin
			if (node_used_q[i] && node_ident_q[i] == ent_q.item.node_id) begin
				hit     = 1'b1;
				hit_idx = ND_W'(i);
			end
			if (!node_used_q[i]) begin
				free     = 1'b1;
				free_idx = ND_W'(i);
			end
		end
	end

	assign base_addr  = SL_W'(nd_q) * SL_W'(SIGNALS_PER_NODE) + SL_W'(k_q);
	assign alloc_addr = SL_W'(nd_q) * SL_W'(SIGNALS_PER_NODE) + SL_W'(node_cnt_q[nd_q]);
	assign slot_more  = node_used_q[nd_q] && (k_q < node_cnt_q[nd_q]);
	assign cnt_full   = (node_cnt_q[nd_q] >= CNT_W'(SIGNALS_PER_NODE));
	assign subj_match = (slot_rd_q.subject == ent_q.item.subject_key);
	assign ring_last  = ((j_q + FILL_W'(1)) == rec_q.fill);
	assign last_node  = (nd_q == ND_W'(NODE_SLOTS - 1));
	assign out_load   = !out_valid_q || !out_stall;
	assign scan_live  = sft_pkg::judge(slot_rd_q.arrivals, slot_rd_q.period, slot_rd_q.last,
			ent_q.item.now_ms, cfg);

	assign gap  = ent_q.item.now_ms - rec_q.last;
	assign sum3 = {rec_q.period[30:0], 1'b0} + rec_q.period + gap;

	assign lo_n = (j_q == '0 || ring_rd_q < lo_q) ? ring_rd_q : lo_q;
	assign hi_n = (j_q == '0 || ring_rd_q > hi_q) ? ring_rd_q : hi_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sft_pkg::ST_IDLE: begin
				if (q_valid) begin
					unique case (q_entry.op)
						sft_pkg::OP_READING, sft_pkg::OP_QUERY: state_d = sft_pkg::ST_NODE;
						sft_pkg::OP_SCAN:                       state_d = sft_pkg::ST_SCAN_RD;
						sft_pkg::OP_NONE:                       state_d = sft_pkg::ST_DONE;
					endcase
				end
			end
			sft_pkg::ST_NODE: begin
				if (hit || (ent_q.op == sft_pkg::OP_READING && free)) begin
					state_d = sft_pkg::ST_SLOT_RD;
				end else begin
					state_d = sft_pkg::ST_DONE;
				end
			end
			sft_pkg::ST_SLOT_RD: begin
				if (slot_more) begin
					state_d = sft_pkg::ST_SLOT_CMP;
				end else if (ent_q.op == sft_pkg::OP_READING && !cnt_full) begin
					state_d = sft_pkg::ST_UPDATE;
				end else begin
					state_d = sft_pkg::ST_DONE;
				end
			end
			sft_pkg::ST_SLOT_CMP: begin
				if (!subj_match) begin
					state_d = sft_pkg::ST_SLOT_RD;
				end else if (ent_q.op == sft_pkg::OP_READING) begin
					state_d = sft_pkg::ST_UPDATE;
				end else begin
					state_d = sft_pkg::ST_DONE;
				end
			end
			sft_pkg::ST_UPDATE: begin
				state_d = ent_q.item.has_value ? sft_pkg::ST_RING_RD : sft_pkg::ST_WRITE;
			end
			sft_pkg::ST_RING_RD:   state_d = sft_pkg::ST_RING_EVAL;
			sft_pkg::ST_RING_EVAL: state_d = ring_last ? sft_pkg::ST_WRITE : sft_pkg::ST_RING_RD;
			sft_pkg::ST_WRITE:     state_d = sft_pkg::ST_DONE;
			sft_pkg::ST_SCAN_RD: begin
				if (slot_more) begin
					state_d = sft_pkg::ST_SCAN_EVAL;
				end else if (last_node) begin
					state_d = sft_pkg::ST_DONE;
				end
			end
			sft_pkg::ST_SCAN_EVAL: state_d = sft_pkg::ST_SCAN_RD;
			sft_pkg::ST_DONE:      state_d = out_load ? sft_pkg::ST_IDLE : sft_pkg::ST_DONE;
			default:               state_d = sft_pkg::ST_IDLE;
		endcase
	end

	// memory and queue control
	always_comb begin
		q_pop   = (state_q == sft_pkg::ST_IDLE) && q_valid;
		slot_we = (state_q == sft_pkg::ST_WRITE);
		slot_ra = base_addr;
		ring_we = (state_q == sft_pkg::ST_UPDATE) && ent_q.item.has_value;
		ring_wa = RA_W'(sl_q) * RA_W'(RING_DEPTH) + RA_W'(rec_q.head);
		ring_ra = RA_W'(sl_q) * RA_W'(RING_DEPTH) + RA_W'(j_q);
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[sl_q] <= rec_q;
		end
		slot_rd_q <= slot_mem[slot_ra];
		if (ring_we) begin
			ring_mem[ring_wa] <= ent_q.item.sample_value;
		end
		ring_rd_q <= ring_mem[ring_ra];
	end

	function automatic sft_pkg::out_item_t report(input rec_t r, input logic [1:0] live);
		sft_pkg::out_item_t o;
		o              = '0;
		o.status       = sft_pkg::STATUS_OK;
		o.liveness     = live;
		o.mean_period  = r.period;
		o.history_min  = r.low;
		o.history_max  = r.high;
		o.history_fill = 7'(r.fill);
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sft_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NODE_SLOTS; i++) begin
				node_used_q[i] <= 1'b0;
				node_cnt_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == sft_pkg::ST_DONE && out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == sft_pkg::ST_NODE && !hit && ent_q.op == sft_pkg::OP_READING
					&& free) begin
				node_used_q[free_idx] <= 1'b1;
				node_cnt_q[free_idx]  <= '0;
			end
			if (state_q == sft_pkg::ST_SLOT_RD && !slot_more && ent_q.op == sft_pkg::OP_READING
					&& !cnt_full) begin
				node_cnt_q[nd_q] <= node_cnt_q[nd_q] + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sft_pkg::ST_IDLE: begin
				ent_q     <= q_entry;
				nd_q      <= '0;
				k_q       <= '0;
				overdue_q <= '0;
				stale_q   <= '0;
				res_q     <= '0;
			end
			sft_pkg::ST_NODE: begin
				k_q <= '0;
				if (hit) begin
					nd_q <= hit_idx;
				end else if (ent_q.op == sft_pkg::OP_READING && free) begin
					nd_q                   <= free_idx;
					node_ident_q[free_idx] <= ent_q.item.node_id;
				end else if (ent_q.op == sft_pkg::OP_READING) begin
					res_q.status <= sft_pkg::STATUS_NODE_FULL;
				end else begin
					res_q.status   <= sft_pkg::STATUS_NOT_FOUND;
					res_q.liveness <= sft_pkg::LIVE_STALE;
				end
			end
			sft_pkg::ST_SLOT_RD: begin
				if (slot_more) begin
					sl_q <= base_addr;
				end else if (ent_q.op == sft_pkg::OP_READING && !cnt_full) begin
					sl_q  <= alloc_addr;
					rec_q <= '{subject: ent_q.item.subject_key, default: '0};
				end else if (ent_q.op == sft_pkg::OP_READING) begin
					res_q.status <= sft_pkg::STATUS_SLOTS_FULL;
				end else begin
					res_q.status   <= sft_pkg::STATUS_NOT_FOUND;
					res_q.liveness <= sft_pkg::LIVE_STALE;
				end
			end
			sft_pkg::ST_SLOT_CMP: begin
				k_q <= k_q + CNT_W'(1);
				if (subj_match) begin
					rec_q <= slot_rd_q;
					res_q <= report(slot_rd_q, sft_pkg::judge(slot_rd_q.arrivals, slot_rd_q.period,
							slot_rd_q.last, ent_q.item.now_ms, cfg));
				end
			end
			sft_pkg::ST_UPDATE: begin
				// 3:1 smoothing of the gap, wrapping at 32 bits
				if (rec_q.arrivals != 32'd0) begin
					rec_q.period <= (rec_q.period == 32'd0) ? gap : {2'b00, sum3[31:2]};
				end
				rec_q.last <= ent_q.item.now_ms;
				if (rec_q.arrivals != 32'hFFFF_FFFF) begin
					rec_q.arrivals <= rec_q.arrivals + 32'd1;
				end
				if (ent_q.item.has_value) begin
					rec_q.head <= (rec_q.head == HEAD_W'(RING_DEPTH - 1)) ? '0
							: rec_q.head + HEAD_W'(1);
					if (rec_q.fill < FILL_W'(RING_DEPTH)) begin
						rec_q.fill <= rec_q.fill + FILL_W'(1);
					end
				end
				j_q <= '0;
			end
			sft_pkg::ST_RING_RD: begin
			end
			sft_pkg::ST_RING_EVAL: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
				j_q  <= j_q + FILL_W'(1);
				if (ring_last) begin
					rec_q.low  <= lo_n;
					rec_q.high <= hi_n;
				end
			end
			sft_pkg::ST_WRITE: begin
				res_q <= report(rec_q, sft_pkg::judge(rec_q.arrivals, rec_q.period, rec_q.last,
						ent_q.item.now_ms, cfg));
			end
			sft_pkg::ST_SCAN_RD: begin
				if (!slot_more && !last_node) begin
					nd_q <= nd_q + ND_W'(1);
					k_q  <= '0;
				end
				if (!slot_more && last_node) begin
					res_q.overdue_total <= overdue_q;
					res_q.stale_total   <= stale_q;
				end
			end
			sft_pkg::ST_SCAN_EVAL: begin
				k_q <= k_q + CNT_W'(1);
				if (scan_live != sft_pkg::LIVE_OK && overdue_q != 8'hFF) begin
					overdue_q <= overdue_q + 8'd1;
				end
				if (scan_live == sft_pkg::LIVE_STALE && stale_q != 8'hFF) begin
					stale_q <= stale_q + 8'd1;
				end
			end
			sft_pkg::ST_DONE: begin
				if (out_load) begin
					out_item_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

@@ src/signal_freshness_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// signal_freshness_tracker_unit
// Tracks per-node signals: arrival period, history min/max and liveness.
// ----------------------------------------------------------------------------
// Items are taken one at a time by a sequencer behind a two-entry queue; the
// result leaves through an output register, so a new item can queue while a
// result waits. Signal slots and history rings sit in memories with a
// registered read, so each slot entry is read and then compared, and each
// history entry is read and then evaluated. A reading searches the slots of
// its node, allocates a slot when the signal is new and, when it carries a
// value, walks the history fill; a query searches the slots only; an overdue
// scan visits every node and every signal that it holds. The node table
// is in flip-flops cleared by reset, so no clearing pass follows reset.
module signal_freshness_tracker_unit #(
	parameter int NODE_SLOTS       = 16,
	parameter int SIGNALS_PER_NODE = 8,
	parameter int RING_DEPTH       = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  sft_pkg::in_item_t         in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output sft_pkg::out_item_t        out_item,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sft_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	sft_pkg::cfg_t         cfg_q;
	logic                  q_valid;
	logic                  q_pop;
	sft_pkg::queue_entry_t q_entry;
	logic                  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_ms   <= sft_pkg::FLOOR_RESET;
			cfg_q.ceiling_ms <= sft_pkg::CEILING_RESET;
			cfg_q.default_ms <= sft_pkg::DEFAULT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				sft_pkg::REG_FLOOR:   cfg_q.floor_ms   <= pwdata[15:0];
				sft_pkg::REG_CEILING: cfg_q.ceiling_ms <= pwdata[15:0];
				sft_pkg::REG_DEFAULT: cfg_q.default_ms <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			sft_pkg::REG_FLOOR:   prdata = {16'd0, cfg_q.floor_ms};
			sft_pkg::REG_CEILING: prdata = {16'd0, cfg_q.ceiling_ms};
			sft_pkg::REG_DEFAULT: prdata = {16'd0, cfg_q.default_ms};
			default:              prdata = 32'd0;
		endcase
	end

	sft_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	sft_back #(
		.NODE_SLOTS       (NODE_SLOTS),
		.SIGNALS_PER_NODE (SIGNALS_PER_NODE),
		.RING_DEPTH       (RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	a_not_found_stale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == sft_pkg::STATUS_NOT_FOUND
		|-> out_item.liveness == sft_pkg::LIVE_STALE)
		else $error("unknown signal not reported stale");

	a_failed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == sft_pkg::STATUS_NODE_FULL
		|| out_item.status == sft_pkg::STATUS_SLOTS_FULL)
		|-> out_item.mean_period == 32'd0 && out_item.history_fill == 7'd0)
		else $error("failed reading carries data");

	a_totals_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.stale_total <= out_item.overdue_total)
		else $error("stale total above overdue total");

endmodule

@@ sim/tb_signal_freshness_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signal_freshness_tracker_unit
// Drives readings, liveness queries and overdue scans into the tracker under
// several period settings. A scoreboard keeps its own node, slot and history
// tables, predicts every result and checks each delivered item field by field.
// ----------------------------------------------------------------------------

class freshness_scoreboard;
	localparam int NODES = 16;
	localparam int PER_NODE = 8;
	localparam int DEPTH = 64;
	localparam int SLOTS = NODES * PER_NODE;

	logic [15:0] floor_ms, ceiling_ms, default_ms;
	bit          node_used[NODES];
	logic [7:0]  node_ident[NODES];
	int          node_count[NODES];
	logic [15:0] subj[SLOTS];
	logic [31:0] period[SLOTS], last_ms[SLOTS], arrivals[SLOTS];
	int          head[SLOTS], fill[SLOTS];
	logic signed [31:0] lo[SLOTS], hi[SLOTS];
	logic signed [31:0] ring[SLOTS][DEPTH];
	sft_pkg::out_item_t expected_q[$];
	int          errors;
	int          kind_seen[4];
	int          status_seen[4];
	int          live_seen[3];

	function new();
		floor_ms = sft_pkg::FLOOR_RESET;
		ceiling_ms = sft_pkg::CEILING_RESET;
		default_ms = sft_pkg::DEFAULT_RESET;
		errors = 0;
		for (int i = 0; i < NODES; i++) begin
			node_used[i] = 0;
			node_ident[i] = 0;
			node_count[i] = 0;
		end
		for (int s = 0; s < SLOTS; s++) begin
			subj[s] = 0; period[s] = 0; last_ms[s] = 0; arrivals[s] = 0;
			head[s] = 0; fill[s] = 0; lo[s] = 0; hi[s] = 0;
		end
		foreach (kind_seen[i]) kind_seen[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		foreach (live_seen[i]) live_seen[i] = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [15:0] v);
		if (idx == sft_pkg::REG_FLOOR) floor_ms = v;
		else if (idx == sft_pkg::REG_CEILING) ceiling_ms = v;
		else if (idx == sft_pkg::REG_DEFAULT) default_ms = v;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function logic [1:0] freshness_of(int sl, logic [31:0] now);
		logic [31:0] p, age;
		if (sl < 0 || arrivals[sl] == 0) return sft_pkg::LIVE_STALE;
		p = (period[sl] == 0) ? {16'd0, default_ms} : period[sl];
		if (p < {16'd0, floor_ms}) p = {16'd0, floor_ms};
		else if (p > {16'd0, ceiling_ms}) p = {16'd0, ceiling_ms};
		age = now - last_ms[sl];
		if (age <= (p * 32'd5) / 32'd2) return sft_pkg::LIVE_OK;
		if (age <= p * 32'd6) return sft_pkg::LIVE_LATE;
		return sft_pkg::LIVE_STALE;
	endfunction

	function int find_node(logic [7:0] id);
		for (int i = 0; i < NODES; i++)
			if (node_used[i] && node_ident[i] == id) return i;
		return -1;
	endfunction

	function int find_slot(int nd, logic [15:0] s);
		for (int k = 0; k < node_count[nd]; k++)
			if (subj[nd * PER_NODE + k] == s) return nd * PER_NODE + k;
		return -1;
	endfunction

	function void fill_report(int sl, logic [31:0] now, ref sft_pkg::out_item_t r);
		r.status = sft_pkg::STATUS_OK;
		r.liveness = freshness_of(sl, now);
		r.mean_period = period[sl];
		r.history_min = lo[sl];
		r.history_max = hi[sl];
		r.history_fill = fill[sl][6:0];
	endfunction

	function void note(sft_pkg::in_item_t it);
		sft_pkg::out_item_t r;
		int nd, sl;
		logic [31:0] gap, ov, st;
		logic [1:0] l;
		r = '0;
		kind_seen[it.kind]++;
		if (it.kind == sft_pkg::KIND_READING) begin
			nd = find_node(it.node_id);
			if (nd < 0) begin
				for (int i = 0; i < NODES; i++)
					if (!node_used[i]) begin
						nd = i;
						break;
					end
				if (nd >= 0) begin
					node_used[nd] = 1;
					node_ident[nd] = it.node_id;
					node_count[nd] = 0;
				end
			end
			if (nd < 0) begin
				r.status = sft_pkg::STATUS_NODE_FULL;
			end else begin
				sl = find_slot(nd, it.subject_key);
				if (sl < 0 && node_count[nd] >= PER_NODE) begin
					r.status = sft_pkg::STATUS_SLOTS_FULL;
				end else begin
					if (sl < 0) begin
						sl = nd * PER_NODE + node_count[nd];
						node_count[nd]++;
						subj[sl] = it.subject_key;
						period[sl] = 0; last_ms[sl] = 0; arrivals[sl] = 0;
						head[sl] = 0; fill[sl] = 0; lo[sl] = 0; hi[sl] = 0;
					end
					if (arrivals[sl] != 0) begin
						gap = it.now_ms - last_ms[sl];
						period[sl] = (period[sl] == 0) ? gap : ((period[sl] * 32'd3 + gap) >> 2);
					end
					last_ms[sl] = it.now_ms;
					if (arrivals[sl] != 32'hFFFF_FFFF) arrivals[sl]++;
					if (it.has_value) begin
						ring[sl][head[sl]] = it.sample_value;
						head[sl] = (head[sl] + 1) % DEPTH;
						if (fill[sl] < DEPTH) fill[sl]++;
						lo[sl] = ring[sl][0];
						hi[sl] = ring[sl][0];
						for (int j = 0; j < fill[sl]; j++) begin
							if (ring[sl][j] < lo[sl]) lo[sl] = ring[sl][j];
							if (ring[sl][j] > hi[sl]) hi[sl] = ring[sl][j];
						end
					end
					fill_report(sl, it.now_ms, r);
				end
			end
		end else if (it.kind == sft_pkg::KIND_QUERY) begin
			nd = find_node(it.node_id);
			sl = (nd < 0) ? -1 : find_slot(nd, it.subject_key);
			if (sl < 0) begin
				r.status = sft_pkg::STATUS_NOT_FOUND;
				r.liveness = sft_pkg::LIVE_STALE;
			end else begin
				fill_report(sl, it.now_ms, r);
			end
		end else if (it.kind == sft_pkg::KIND_SCAN) begin
			ov = 0;
			st = 0;
			for (int i = 0; i < NODES; i++) begin
				if (!node_used[i]) continue;
				for (int k = 0; k < node_count[i]; k++) begin
					l = freshness_of(i * PER_NODE + k, it.now_ms);
					if (l != sft_pkg::LIVE_OK && ov < 255) ov++;
					if (l == sft_pkg::LIVE_STALE && st < 255) st++;
				end
			end
			r.overdue_total = ov[7:0];
			r.stale_total = st[7:0];
		end
		status_seen[r.status]++;
		if (r.liveness <= sft_pkg::LIVE_STALE) live_seen[r.liveness]++;
		expected_q.push_back(r);
	endfunction

	function void mismatch(string field, logic [31:0] e, logic [31:0] a);
		errors++;
		$display("%0t mismatch on %s: expected %0h, got %0h", $time, field, e, a);
	endfunction

	function void check(sft_pkg::out_item_t got);
		sft_pkg::out_item_t e;
		if (expected_q.size() == 0) begin
			errors++;
			$display("%0t result with nothing expected: %0h", $time, got);
			return;
		end
		e = expected_q.pop_front();
		if (got.status !== e.status) mismatch("status", e.status, got.status);
		if (got.liveness !== e.liveness) mismatch("liveness", e.liveness, got.liveness);
		if (got.mean_period !== e.mean_period)
			mismatch("mean_period", e.mean_period, got.mean_period);
		if (got.history_min !== e.history_min)
			mismatch("history_min", e.history_min, got.history_min);
		if (got.history_max !== e.history_max)
			mismatch("history_max", e.history_max, got.history_max);
		if (got.history_fill !== e.history_fill)
			mismatch("history_fill", e.history_fill, got.history_fill);
		if (got.overdue_total !== e.overdue_total)
			mismatch("overdue_total", e.overdue_total, got.overdue_total);
		if (got.stale_total !== e.stale_total)
			mismatch("stale_total", e.stale_total, got.stale_total);
	endfunction
endclass

module tb_signal_freshness_tracker_unit;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 5000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	sft_pkg::in_item_t in_item;
	sft_pkg::out_item_t out_item;
	logic psel, penable, pwrite, pready;
	logic [sft_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	freshness_scoreboard sb;
	logic [31:0] clock_ms;
	bit quiet;
	int long_hold;
	int hold;
	int idle_cycles;

	signal_freshness_tracker_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// accepted items in both directions, plus the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note(in_item);
			if (out_valid && !out_stall) sb.check(out_item);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles == STALL_LIMIT) begin
				$display("%0t watchdog: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (long_hold > 0) begin
			out_stall <= 1'b1;
			long_hold <= long_hold - 1;
		end else if (hold > 0) begin
			out_stall <= 1'b1;
			hold <= hold - 1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 39) == 0) begin
			out_stall <= 1'b1;
			hold <= $urandom_range(10, 50);
		end else begin
			out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	task automatic send_item(sft_pkg::in_item_t it);
		int r, gap;
		r = $urandom_range(0, 9);
		gap = quiet ? 0 : (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic item(logic [1:0] k, logic [7:0] nd, logic [15:0] s, logic hv,
			logic [31:0] v, logic [31:0] now);
		sft_pkg::in_item_t it;
		it.kind = k;
		it.node_id = nd;
		it.subject_key = s;
		it.has_value = hv;
		it.sample_value = v;
		it.now_ms = now;
		send_item(it);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= sft_pkg::ADDR_W'(idx) << 2;
		pwdata <= {16'($urandom_range(0, 65535)), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_periods(logic [15:0] f, logic [15:0] c, logic [15:0] d);
		settle();
		write_reg(sft_pkg::REG_FLOOR, f);
		write_reg(sft_pkg::REG_CEILING, c);
		write_reg(sft_pkg::REG_DEFAULT, d);
	endtask

	task automatic random_item();
		int r;
		logic [1:0] k;
		logic [7:0] nd;
		logic [15:0] s;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		k = (r < 70) ? sft_pkg::KIND_READING : (r < 88) ? sft_pkg::KIND_QUERY
				: (r < 95) ? sft_pkg::KIND_SCAN : KIND_UNUSED;
		nd = 8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 19) : $urandom_range(0, 255));
		s = 16'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 10)
				: $urandom_range(0, 65535));
		r = $urandom_range(0, 9);
		v = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF : $urandom;
		r = $urandom_range(0, 99);
		if (r < 70) clock_ms = clock_ms + $urandom_range(0, 2000);
		else if (r < 90) clock_ms = clock_ms + $urandom_range(0, 100000);
		else if (r < 95) clock_ms = $urandom;
		item(k, nd, s, $urandom_range(0, 4) != 0, v, clock_ms);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 0;
		long_hold = 0;
		hold = 0;
		idle_cycles = 0;
		clock_ms = 32'd1000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, all kinds, unknown signals, full signal slots
		item(sft_pkg::KIND_QUERY, 8'd0, 16'd0, 1'b0, 32'd0, 32'd0);
		item(sft_pkg::KIND_SCAN, 8'd0, 16'd0, 1'b0, 32'd0, 32'd0);
		item(sft_pkg::KIND_READING, 8'd255, 16'hFFFF, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
		item(sft_pkg::KIND_READING, 8'd255, 16'hFFFF, 1'b1, 32'h7FFF_FFFF, 32'd100);
		item(sft_pkg::KIND_READING, 8'd255, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 32'd400);
		item(sft_pkg::KIND_QUERY, 8'd255, 16'hFFFF, 1'b0, 32'd0, 32'd900);
		item(sft_pkg::KIND_QUERY, 8'd255, 16'hFFFF, 1'b0, 32'd0, 32'd2000);
		item(sft_pkg::KIND_QUERY, 8'd255, 16'hFFFF, 1'b0, 32'd0, 32'h8000_0000);
		item(sft_pkg::KIND_QUERY, 8'd255, 16'd1, 1'b0, 32'd0, 32'd500);
		item(sft_pkg::KIND_READING, 8'd0, 16'd0, 1'b1, 32'd0, 32'd10);
		item(sft_pkg::KIND_READING, 8'd0, 16'd0, 1'b1, 32'hFFFF_FFFF, 32'd10);
		for (int i = 1; i <= 9; i++)
			item(sft_pkg::KIND_READING, 8'd1, 16'(i), 1'b1, 32'(i * 65536), 32'(i * 10));
		item(KIND_UNUSED, 8'd1, 16'd1, 1'b1, 32'd5, 32'd5);
		item(sft_pkg::KIND_SCAN, 8'd0, 16'd0, 1'b0, 32'd0, 32'd5000);
		item(sft_pkg::KIND_SCAN, 8'd0, 16'd0, 1'b0, 32'd0, 32'hFFFF_FFFF);

		// random phases under different period settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: set_periods(16'd1, 16'd65535, 16'd1);
				2: set_periods(16'd65535, 16'd1, 16'd65535);
				3: begin
					set_periods(16'd100, 16'd3000, 16'd500);
					write_reg(REG_SPARE, 16'hFFFF);
				end
				4: set_periods(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
						16'($urandom_range(1, 65535)));
				5: set_periods(sft_pkg::FLOOR_RESET, sft_pkg::CEILING_RESET,
						sft_pkg::DEFAULT_RESET);
				default: ;
			endcase
			quiet = (ph == 3);
			if (ph == 1) long_hold = 400;
			for (int n = 0; n < 170; n++) random_item();
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("items: %0d readings, %0d queries, %0d scans, %0d unused kind",
			sb.kind_seen[sft_pkg::KIND_READING], sb.kind_seen[sft_pkg::KIND_QUERY],
			sb.kind_seen[sft_pkg::KIND_SCAN], sb.kind_seen[KIND_UNUSED]);
		$display("status ok/node full/slots full/not found: %0d/%0d/%0d/%0d",
			sb.status_seen[sft_pkg::STATUS_OK], sb.status_seen[sft_pkg::STATUS_NODE_FULL],
			sb.status_seen[sft_pkg::STATUS_SLOTS_FULL], sb.status_seen[sft_pkg::STATUS_NOT_FOUND]);
		$display("live/late/stale %0d/%0d/%0d", sb.live_seen[sft_pkg::LIVE_OK],
			sb.live_seen[sft_pkg::LIVE_LATE], sb.live_seen[sft_pkg::LIVE_STALE]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

@@ signal_freshness_tracker_unit.f @@
src/sft_pkg.sv
src/sft_front.sv
src/sft_back.sv
src/signal_freshness_tracker_unit.sv
sim/tb_signal_freshness_tracker_unit.sv
